/* rtl/core/fcte_pkg.sv */
// Shared constants, codes and types of the fan curve table engine.
// Depends on nothing; the divider, sequencer, top level and bench import it.
`default_nettype none

package fcte_pkg;

  localparam int FANS    = 8;
  localparam int LEVELS  = 256;
  localparam int FAN_AW  = (FANS > 1) ? $clog2(FANS) : 1;
  localparam int LVL_AW  = $clog2(LEVELS);
  localparam int ADDR_W  = FAN_AW + LVL_AW;
  localparam int DEPTH   = 1 << ADDR_W;
  localparam int SPAN_W  = LVL_AW + 1;
  localparam int CNT_W   = $clog2(LEVELS + 1);

  localparam int OP_W    = 3;
  localparam int FAN_W   = 3;
  localparam int PWM_W   = 8;
  localparam int RPM_W   = 16;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 48;

  localparam logic [RPM_W-1:0]  UNDEF_RPM       = 16'hFFFF;
  localparam logic [RPM_W-1:0]  DEFAULT_TOP_RPM = 16'd3315;
  localparam logic [LVL_AW-1:0] LVL_MAX         = LVL_AW'(LEVELS - 1);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR   = 3'd0,
    OP_DEFAULT = 3'd1,
    OP_SET     = 3'd2,
    OP_BUILD   = 3'd3,
    OP_QUERY   = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_SWEEP,
    ST_SET_RD,
    ST_SET_WR,
    ST_B_RD,
    ST_B_CHK,
    ST_B_DIV,
    ST_B_FILL,
    ST_B_END,
    ST_Q_RD,
    ST_Q_CHK,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [FAN_W-1:0] fan;
    logic [PWM_W-1:0] lvl;
    logic [RPM_W-1:0] rpm;
  } req_t;

  typedef struct packed {
    logic             valid;
    logic [PWM_W-1:0] pwm;
    logic [RPM_W-1:0] cmin;
    logic [RPM_W-1:0] cmax;
    logic             empty;
  } rsp_t;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [RPM_W-1:0]  wdata;
  } mem_req_t;

  typedef struct packed {
    logic              start;
    logic [RPM_W-1:0]  dividend;
    logic [SPAN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [RPM_W-1:0]  quo;
    logic [SPAN_W-1:0] rem;
  } div_rsp_t;

  function automatic logic fan_ok(input logic [FAN_W-1:0] fan);
    return {2'b00, fan} < 5'(FANS);
  endfunction

endpackage

`default_nettype wire

/* rtl/core/fcte_ram.sv */
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module fcte_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end
      rdata_o <= mem[addr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/fcte_div.sv */
// Restoring divider, one quotient bit per cycle, for the interpolation step.
// Depends on fcte_pkg.
`default_nettype none

module fcte_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire fcte_pkg::div_req_t req_i,
  output fcte_pkg::div_rsp_t      rsp_o
);
  import fcte_pkg::*;

  localparam int STEP_W = $clog2(RPM_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [RPM_W-1:0]  quo_q, quo_d;
  logic [SPAN_W-1:0] rem_q, rem_d;
  logic [SPAN_W-1:0] dsr_q, dsr_d;
  logic [SPAN_W:0]   trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    trial  = {rem_q, quo_q[RPM_W-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      // shift in the next dividend bit, subtract where it fits
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = SPAN_W'(trial - {1'b0, dsr_q});
        quo_d = {quo_q[RPM_W-2:0], 1'b1};
      end else begin
        rem_d = trial[SPAN_W-1:0];
        quo_d = {quo_q[RPM_W-2:0], 1'b0};
      end
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(RPM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
      quo_q  <= quo_d;
      rem_q  <= rem_d;
      dsr_q  <= dsr_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

/* rtl/core/fcte_seq.sv */
// Operation sequencer: walks the curve memory for clear, load default, set, build
// and query, and keeps the per-fan defined-entry counts and min/max. Depends on fcte_pkg.
`default_nettype none

module fcte_seq (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          req_valid_i,
  input  wire fcte_pkg::req_t                req_i,
  output logic                               req_ready_o,
  input  wire logic                          out_free_i,
  output fcte_pkg::rsp_t                     rsp_o,
  output fcte_pkg::mem_req_t                 mem_o,
  input  wire logic [fcte_pkg::RPM_W-1:0]    mem_rdata_i,
  output fcte_pkg::div_req_t                 div_o,
  input  wire fcte_pkg::div_rsp_t            div_i
);
  import fcte_pkg::*;

  state_e            state_q, state_d;
  req_t              req_q, req_d;
  logic [ADDR_W-1:0] init_q, init_d;
  logic [LVL_AW-1:0] idx_q, idx_d;
  logic [CNT_W-1:0]  cnt_q [FANS];
  logic [CNT_W-1:0]  cnt_d [FANS];
  logic [RPM_W-1:0]  low_q [FANS];
  logic [RPM_W-1:0]  low_d [FANS];
  logic [RPM_W-1:0]  high_q [FANS];
  logic [RPM_W-1:0]  high_d [FANS];
  logic [PWM_W-1:0]  pwm_q, pwm_d;

  // build
  logic              prev_vld_q, prev_vld_d;
  logic [LVL_AW-1:0] prev_idx_q, prev_idx_d;
  logic [RPM_W-1:0]  a_q, a_d;
  logic [RPM_W-1:0]  b_q, b_d;
  logic              first_vld_q, first_vld_d;
  logic [RPM_W-1:0]  first_val_q, first_val_d;
  logic [LVL_AW-1:0] k_q, k_d;
  logic [RPM_W-1:0]  q_q, q_d;
  logic [SPAN_W-1:0] r_q, r_d;
  logic [SPAN_W-1:0] span_q, span_d;
  logic [RPM_W-1:0]  dq_q, dq_d;
  logic [SPAN_W-1:0] dr_q, dr_d;

  // query
  logic [RPM_W-1:0]  target_q, target_d;
  logic              pass2_q, pass2_d;
  logic              last_vld_q, last_vld_d;
  logic [RPM_W-1:0]  last_val_q, last_val_d;

  logic [FAN_AW-1:0] fan_idx;
  logic              defined;
  logic              adv;
  logic [SPAN_W-1:0] span_now;
  logic [SPAN_W:0]   r_sum;
  logic              wrap;
  logic [SPAN_W-1:0] r_next;
  logic [RPM_W-1:0]  q_next;

  assign fan_idx  = req_q.fan[FAN_AW-1:0];
  assign defined  = (mem_rdata_i != UNDEF_RPM);
  assign span_now = SPAN_W'(idx_q) - SPAN_W'(prev_idx_q);
  assign r_sum    = {1'b0, r_q} + {1'b0, dr_q};
  assign wrap     = (r_sum >= {1'b0, span_q});
  assign r_next   = wrap ? SPAN_W'(r_sum - {1'b0, span_q}) : r_sum[SPAN_W-1:0];
  assign q_next   = q_q + dq_q + RPM_W'(wrap);

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    init_d      = init_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    low_d       = low_q;
    high_d      = high_q;
    pwm_d       = pwm_q;
    prev_vld_d  = prev_vld_q;
    prev_idx_d  = prev_idx_q;
    a_d         = a_q;
    b_d         = b_q;
    first_vld_d = first_vld_q;
    first_val_d = first_val_q;
    k_d         = k_q;
    q_d         = q_q;
    r_d         = r_q;
    span_d      = span_q;
    dq_d        = dq_q;
    dr_d        = dr_q;
    target_d    = target_q;
    pass2_d     = pass2_q;
    last_vld_d  = last_vld_q;
    last_val_d  = last_val_q;
    adv         = 1'b0;
    req_ready_o = 1'b0;
    rsp_o       = '0;
    mem_o       = '0;
    div_o       = '0;

    case (state_q)
      ST_INIT: begin
        mem_o.en    = 1'b1;
        mem_o.we    = 1'b1;
        mem_o.addr  = init_q;
        mem_o.wdata = UNDEF_RPM;
        init_d      = init_q + 1'b1;
        if (&init_q) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          req_d       = req_i;
          idx_d       = '0;
          pwm_d       = '0;
          prev_vld_d  = 1'b0;
          first_vld_d = 1'b0;
          pass2_d     = 1'b0;
          last_vld_d  = 1'b0;
          target_d    = req_i.rpm;
          if (!fan_ok(req_i.fan)) begin
            state_d = ST_RESP;
          end else begin
            case (req_i.op)
              OP_CLEAR, OP_DEFAULT: state_d = ST_SWEEP;
              OP_SET: begin
                state_d = ({1'b0, req_i.lvl} < 9'(LEVELS)) ? ST_SET_RD : ST_RESP;
              end
              OP_BUILD: state_d = ST_B_RD;
              OP_QUERY: state_d = ST_Q_RD;
              default:  state_d = ST_RESP;
            endcase
          end
        end
      end

      ST_SWEEP: begin
        mem_o.en    = 1'b1;
        mem_o.we    = 1'b1;
        mem_o.addr  = {fan_idx, idx_q};
        mem_o.wdata = UNDEF_RPM;
        if (req_q.op == OP_DEFAULT) begin
          if (idx_q == '0) begin
            mem_o.wdata = '0;
          end else if (idx_q == LVL_MAX) begin
            mem_o.wdata = DEFAULT_TOP_RPM;
          end
        end
        idx_d = idx_q + 1'b1;
        if (idx_q == LVL_MAX) begin
          cnt_d[fan_idx] = (req_q.op == OP_DEFAULT) ? CNT_W'(2) : '0;
          state_d        = ST_RESP;
        end
      end

      ST_SET_RD: begin
        mem_o.en   = 1'b1;
        mem_o.addr = {fan_idx, req_q.lvl[LVL_AW-1:0]};
        state_d    = ST_SET_WR;
      end

      ST_SET_WR: begin
        // read-modify-write: adjust the count by the change in definedness
        mem_o.en       = 1'b1;
        mem_o.we       = 1'b1;
        mem_o.addr     = {fan_idx, req_q.lvl[LVL_AW-1:0]};
        mem_o.wdata    = req_q.rpm;
        cnt_d[fan_idx] = cnt_q[fan_idx] + CNT_W'(req_q.rpm != UNDEF_RPM) - CNT_W'(defined);
        state_d        = ST_RESP;
      end

      ST_B_RD: begin
        mem_o.en   = 1'b1;
        mem_o.addr = {fan_idx, idx_q};
        state_d    = ST_B_CHK;
      end

      ST_B_CHK: begin
        if (defined) begin
          if (!first_vld_q) begin
            first_vld_d = 1'b1;
            first_val_d = mem_rdata_i;
          end
          b_d = mem_rdata_i;
          if (prev_vld_q && (span_now != SPAN_W'(1))) begin
            // gap behind this point: divide the rise by the span first
            div_o.start    = 1'b1;
            div_o.dividend = (mem_rdata_i >= a_q) ? mem_rdata_i - a_q : a_q - mem_rdata_i;
            div_o.divisor  = span_now;
            span_d         = span_now;
            state_d        = ST_B_DIV;
          end else begin
            prev_vld_d = 1'b1;
            prev_idx_d = idx_q;
            a_d        = mem_rdata_i;
            adv        = 1'b1;
          end
        end else begin
          adv = 1'b1;
        end
      end

      ST_B_DIV: begin
        if (div_i.done) begin
          if (b_q >= a_q) begin
            dq_d = div_i.quo;
            dr_d = div_i.rem;
          end else if (div_i.rem == '0) begin
            dq_d = RPM_W'(0) - div_i.quo;
            dr_d = '0;
          end else begin
            dq_d = ~div_i.quo;
            dr_d = span_q - div_i.rem;
          end
          q_d     = a_q;
          r_d     = '0;
          k_d     = prev_idx_q + 1'b1;
          state_d = ST_B_FILL;
        end
      end

      ST_B_FILL: begin
        // every filled level was undefined before, so it adds one to the count
        mem_o.en       = 1'b1;
        mem_o.we       = 1'b1;
        mem_o.addr     = {fan_idx, k_q};
        mem_o.wdata    = q_next;
        cnt_d[fan_idx] = cnt_q[fan_idx] + CNT_W'(1);
        q_d            = q_next;
        r_d            = r_next;
        k_d            = k_q + 1'b1;
        if (k_q == idx_q - 1'b1) begin
          prev_vld_d = 1'b1;
          prev_idx_d = idx_q;
          a_d        = b_q;
          adv        = 1'b1;
        end
      end

      ST_B_END: begin
        low_d[fan_idx]  = first_vld_q ? first_val_q : '0;
        high_d[fan_idx] = prev_vld_q ? a_q : '0;
        state_d         = ST_RESP;
      end

      ST_Q_RD: begin
        mem_o.en   = 1'b1;
        mem_o.addr = {fan_idx, idx_q};
        state_d    = ST_Q_CHK;
      end

      ST_Q_CHK: begin
        if (defined && (mem_rdata_i >= target_q)) begin
          pwm_d   = PWM_W'(idx_q);
          state_d = ST_RESP;
        end else begin
          if (defined) begin
            last_vld_d = 1'b1;
            last_val_d = mem_rdata_i;
          end
          if (idx_q == LVL_MAX) begin
            // nothing reached the target: retry with the last defined value
            if (!pass2_q && (last_vld_q || defined)) begin
              target_d = defined ? mem_rdata_i : last_val_q;
              pass2_d  = 1'b1;
              idx_d    = '0;
              state_d  = ST_Q_RD;
            end else begin
              state_d = ST_RESP;
            end
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_Q_RD;
          end
        end
      end

      ST_RESP: begin
        if (out_free_i) begin
          rsp_o.valid = 1'b1;
          if (fan_ok(req_q.fan)) begin
            rsp_o.pwm   = pwm_q;
            rsp_o.cmin  = low_q[fan_idx];
            rsp_o.cmax  = high_q[fan_idx];
            rsp_o.empty = (cnt_q[fan_idx] == '0);
          end else begin
            rsp_o.empty = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    // advance the build scan to the next level, or finish
    if (adv) begin
      if (idx_q == LVL_MAX) begin
        state_d = ST_B_END;
      end else begin
        idx_d   = idx_q + 1'b1;
        state_d = ST_B_RD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      init_q      <= '0;
      cnt_q       <= '{default: '0};
      low_q       <= '{default: '0};
      high_q      <= '{default: '0};
      prev_vld_q  <= 1'b0;
      first_vld_q <= 1'b0;
      pass2_q     <= 1'b0;
      last_vld_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      cnt_q       <= cnt_d;
      low_q       <= low_d;
      high_q      <= high_d;
      prev_vld_q  <= prev_vld_d;
      first_vld_q <= first_vld_d;
      pass2_q     <= pass2_d;
      last_vld_q  <= last_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    idx_q       <= idx_d;
    pwm_q       <= pwm_d;
    prev_idx_q  <= prev_idx_d;
    a_q         <= a_d;
    b_q         <= b_d;
    first_val_q <= first_val_d;
    k_q         <= k_d;
    q_q         <= q_d;
    r_q         <= r_d;
    span_q      <= span_d;
    dq_q        <= dq_d;
    dr_q        <= dr_d;
    target_q    <= target_d;
    last_val_q  <= last_val_d;
  end

endmodule

`default_nettype wire

/* rtl/core/fan_curve_table_engine.sv */
// Top level of the fan curve table engine: stream ports, result register,
// curve memory, divider and sequencer. Depends on fcte_pkg, fcte_ram,
// fcte_div and fcte_seq.
`default_nettype none

// Each of eight fans owns a 256-entry curve that maps a PWM level to an rpm
// value, held in one 2048 x 16 single-port RAM; 65535 marks an undefined
// entry. One item carries one operation (clear, load default curve, set
// point, build, query) and gives exactly one result item. After reset the
// block sweeps the whole RAM to the undefined value, one entry a cycle, and
// s_axis_tready stays low until the sweep is done. Items are handled one at
// a time; the cost of each is set by the single RAM port, which is read and
// written at most once a cycle:
//   clear / load default : one write per level, then the result
//   set point            : accept, read old value, write new one,
//                          result
//   build                : a read and a check per level scanned, plus for
//                          every gap a wait on the divider and one write
//                          per filled level
//   query                : a read and a check per level scanned, and a new scan when
//                          a second pass on the last defined value is needed
// Build fills each gap with floor((a*(j-k) + b*(k-i))/(j-i)) using an
// incremental quotient/remainder walk, so one division per gap suffices. A
// waiting result sits in the output register and the next item is taken
// meanwhile. curve_empty comes from a per-fan count of defined entries.
module fan_curve_table_engine (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // fan [2:0], pwm_level [10:3], rpm_value [26:11], zero above
  input  wire logic [fcte_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // operation [2:0]
  input  wire logic [fcte_pkg::OP_W-1:0]          s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // pwm_out [7:0], curve_min [23:8], curve_max [39:24], curve_empty [40], zero above
  output logic      [fcte_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
  import fcte_pkg::*;

  req_t                  in_req;
  rsp_t                  rsp;
  mem_req_t              mem_req;
  logic [RPM_W-1:0]      mem_rdata;
  div_req_t              div_req;
  div_rsp_t              div_rsp;
  logic                  out_free;
  logic                  in_acc;

  logic                  m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] m_data_q, m_data_d;
  logic                  pending_q, pending_d;

  // unpack the incoming item
  assign in_req.op  = s_axis_tuser;
  assign in_req.fan = s_axis_tdata[FAN_W-1:0];
  assign in_req.lvl = s_axis_tdata[FAN_W +: PWM_W];
  assign in_req.rpm = s_axis_tdata[FAN_W+PWM_W +: RPM_W];

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;

  fcte_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_i       (in_req),
    .req_ready_o (s_axis_tready),
    .out_free_i  (out_free),
    .rsp_o       (rsp),
    .mem_o       (mem_req),
    .mem_rdata_i (mem_rdata),
    .div_o       (div_req),
    .div_i       (div_rsp)
  );

  fcte_ram #(
    .WIDTH (RPM_W),
    .DEPTH (DEPTH)
  ) u_curve_ram (
    .clk_i   (clk_i),
    .en_i    (mem_req.en),
    .we_i    (mem_req.we),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (mem_rdata)
  );

  fcte_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // result register: load a finished result, hold it until taken
  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (rsp.valid) begin
      m_valid_d = 1'b1;
      m_data_d  = {{(OUT_DATA_W - PWM_W - 2*RPM_W - 1){1'b0}},
                   rsp.empty, rsp.cmax, rsp.cmin, rsp.pwm};
    end
  end

  // track the item in flight between acceptance and its result
  always_comb begin
    pending_d = pending_q;
    if (in_acc) begin
      pending_d = 1'b1;
    end else if (rsp.valid) begin
      pending_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      pending_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
      pending_q <= pending_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // every item keeps the sequencer busy for at least the following cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("input taken again straight after an accepted item");

  // a result is only loaded when the output register can take it
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> out_free)
    else $error("result loaded over an untaken result");

  // one result per accepted item: none without an item, no item while one is open
  a_result_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> pending_q)
    else $error("result without an accepted item");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !pending_q)
    else $error("item accepted while the previous one is still open");

endmodule

`default_nettype wire

/* tb/sv/tb_fan_curve_table_engine.sv */
`timescale 1ns / 100ps
// Self-checking bench for fan_curve_table_engine: a shadow of the per-fan curve tables predicts every result.
// Depends on fcte_pkg and the engine RTL; needs no files or arguments.

module tb_fan_curve_table_engine;
  import fcte_pkg::*;

  localparam int ITEM_TARGET  = 1750;
  localparam int STALL_LIMIT  = 30000;
  localparam int LONG_HOLD    = 3000;
  localparam int HOLD_AT      = 400;
  localparam int CALM_TAIL    = 150;
  localparam int MAX_PRINTS   = 100;
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [PWM_W-1:0] pwm;
    logic [RPM_W-1:0] cmin;
    logic [RPM_W-1:0] cmax;
    logic             empty;
  } fan_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [OP_W-1:0]       s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b1;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // Shadow state of the engine
  logic [RPM_W-1:0] curve_shadow [FANS][LEVELS];
  logic [RPM_W-1:0] min_shadow [FANS];
  logic [RPM_W-1:0] max_shadow [FANS];

  req_t        item_q[$];
  fan_result_t result_q[$];

  int   real_items = 0;
  int   errors = 0;
  int   results_seen = 0;
  int   stall_cycles = 0;
  logic in_taken = 1'b0;
  logic quiet = 1'b0;
  int   send_gap = 0;
  int   recv_gap = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;

  fan_curve_table_engine uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- shadow

  function automatic bit curve_is_empty(int f);
    for (int i = 0; i < LEVELS; i++)
      if (curve_shadow[f][i] != UNDEF_RPM) return 1'b0;
    return 1'b1;
  endfunction

  // Lowest defined level reaching target, or -1 when none does
  function automatic int lowest_level_reaching(int f, logic [RPM_W-1:0] target);
    for (int i = 0; i < LEVELS; i++)
      if (curve_shadow[f][i] != UNDEF_RPM && curve_shadow[f][i] >= target) return i;
    return -1;
  endfunction

  function automatic void interpolate_curve(int f);
    int     prev;
    int     first;
    longint a;
    longint b;
    prev  = -1;
    first = -1;
    for (int j = 0; j < LEVELS; j++) begin
      if (curve_shadow[f][j] == UNDEF_RPM) continue;
      if (first < 0) first = j;
      if (prev >= 0 && j > prev + 1) begin
        a = curve_shadow[f][prev];
        b = curve_shadow[f][j];
        // floor((a*(j-k) + b*(k-i)) / (j-i)), the end point included
        for (int k = prev + 1; k <= j; k++)
          curve_shadow[f][k] = RPM_W'((a * (j - k) + b * (k - prev)) / (j - prev));
      end
      prev = j;
    end
    if (first < 0) begin
      min_shadow[f] = '0;
      max_shadow[f] = '0;
    end else begin
      min_shadow[f] = curve_shadow[f][first];
      max_shadow[f] = curve_shadow[f][prev];
    end
  endfunction

  function automatic int lookup_level(int f, logic [RPM_W-1:0] target);
    int lvl;
    lvl = lowest_level_reaching(f, target);
    // Nothing reaches the target: fall back on the last defined value
    if (lvl < 0) begin
      for (int i = LEVELS - 1; i >= 0; i--) begin
        if (curve_shadow[f][i] != UNDEF_RPM) begin
          lvl = lowest_level_reaching(f, curve_shadow[f][i]);
          break;
        end
      end
    end
    return (lvl < 0) ? 0 : lvl;
  endfunction

  // Apply one item to the shadow and return the result it must give
  function automatic fan_result_t apply_fan_item(req_t req);
    fan_result_t res;
    int          f;
    f = int'(req.fan);
    res = '0;
    if (!fan_ok(req.fan)) begin
      res.empty = 1'b1;
      return res;
    end
    case (req.op)
      OP_CLEAR: begin
        for (int i = 0; i < LEVELS; i++) curve_shadow[f][i] = UNDEF_RPM;
      end
      OP_DEFAULT: begin
        for (int i = 0; i < LEVELS; i++) curve_shadow[f][i] = UNDEF_RPM;
        curve_shadow[f][0]          = '0;
        curve_shadow[f][LEVELS - 1] = DEFAULT_TOP_RPM;
      end
      OP_SET: begin
        if (int'(req.lvl) < LEVELS) curve_shadow[f][req.lvl] = req.rpm;
      end
      OP_BUILD: interpolate_curve(f);
      OP_QUERY: res.pwm = PWM_W'(lookup_level(f, req.rpm));
      default: ;
    endcase
    res.cmin  = min_shadow[f];
    res.cmax  = max_shadow[f];
    res.empty = curve_is_empty(f);
    return res;
  endfunction

  // -------------------------------------------------------------- stimulus

  task automatic add_item(logic [OP_W-1:0] op, int fan, int lvl, int rpm);
    req_t req;
    req.op  = op;
    req.fan = FAN_W'(fan);
    req.lvl = PWM_W'(lvl);
    req.rpm = RPM_W'(rpm);
    item_q.push_back(req);
    // spare codes are ignored by the engine, so leave them out of the count
    if (op <= OP_QUERY) real_items++;
  endtask

  function automatic int pick_point_rpm();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return int'(UNDEF_RPM);
    if (r < 25) return $urandom_range(0, 65535);
    return $urandom_range(0, 5000);
  endfunction

  function automatic int pick_target_rpm();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return int'(UNDEF_RPM);
      2: return $urandom_range(0, 65535);
      default: return $urandom_range(0, 5000);
    endcase
  endfunction

  task automatic fill_directed();
    // empty table: query and build
    add_item(OP_QUERY, 0, 0, 0);
    add_item(OP_BUILD, 0, 255, 65535);
    // spare operation codes
    for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
      add_item(OP_W'(op), op, $urandom_range(0, 255), $urandom_range(0, 65535));
    // default curve, before and after build
    add_item(OP_DEFAULT, 7, 0, 0);
    add_item(OP_QUERY, 7, 0, 0);
    add_item(OP_QUERY, 7, 0, int'(DEFAULT_TOP_RPM));
    add_item(OP_QUERY, 7, 0, int'(UNDEF_RPM));
    add_item(OP_BUILD, 7, 0, 0);
    add_item(OP_QUERY, 7, 128, 1000);
    add_item(OP_QUERY, 7, 255, 65534);
    // falling curve, extreme values at extreme levels
    add_item(OP_SET, 0, 0, 65534);
    add_item(OP_SET, 0, 255, 0);
    add_item(OP_SET, 0, 128, int'(UNDEF_RPM));
    add_item(OP_SET, 0, 100, 40000);
    add_item(OP_BUILD, 0, 0, 0);
    add_item(OP_QUERY, 0, 0, int'(UNDEF_RPM));
    add_item(OP_QUERY, 0, 0, 50000);
    // undefine a point after build, then query the gap-ridden table
    add_item(OP_SET, 0, 0, int'(UNDEF_RPM));
    add_item(OP_QUERY, 0, 0, 65000);
    // clear keeps the latched min and max
    add_item(OP_CLEAR, 7, 0, 0);
    add_item(OP_QUERY, 7, 0, 100);
    // single point table
    add_item(OP_SET, 3, 77, 0);
    add_item(OP_BUILD, 3, 0, 0);
    add_item(OP_QUERY, 3, 0, 1);
    add_item(OP_CLEAR, 0, 0, 0);
  endtask

  task automatic fill_random();
    int fan;
    int n;
    while (real_items < ITEM_TARGET) begin
      fan = $urandom_range(0, FANS - 1);
      if ($urandom_range(0, 9) == 0) begin
        // noise: any code, any field
        add_item(OP_W'($urandom_range(0, 7)), fan, $urandom_range(0, 255),
                 $urandom_range(0, 65535));
      end else begin
        case ($urandom_range(0, 3))
          0, 3: add_item(OP_CLEAR, fan, $urandom_range(0, 255), $urandom_range(0, 65535));
          1: add_item(OP_DEFAULT, fan, $urandom_range(0, 255), $urandom_range(0, 65535));
          default: ;
        endcase
        n = $urandom_range(0, 6);
        for (int p = 0; p < n; p++)
          add_item(OP_SET, fan, $urandom_range(0, 255), pick_point_rpm());
        if ($urandom_range(0, 99) < 85)
          add_item(OP_BUILD, fan, $urandom_range(0, 255), $urandom_range(0, 65535));
        n = $urandom_range(1, 4);
        for (int q = 0; q < n; q++)
          add_item(OP_QUERY, fan, $urandom_range(0, 255), pick_target_rpm());
      end
    end
  endtask

  // ---------------------------------------------------------------- driver

  // Present items at the falling edge; hold an item until it is taken
  always @(negedge clk_i) begin
    req_t nxt;
    logic calm;
    if (rst_ni) begin
      calm = quiet || (item_q.size() < CALM_TAIL);
      if ($urandom_range(0, 299) == 0) quiet <= ~quiet;
      if (!s_axis_tvalid || in_taken) begin
        if (send_gap != 0) begin
          send_gap      <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (item_q.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          send_gap      <= $urandom_range(1, 14) - 1;
          s_axis_tvalid <= 1'b0;
        end else begin
          nxt           = item_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= nxt.op;
          s_axis_tdata  <= IN_DATA_W'({nxt.rpm, nxt.lvl, nxt.fan});
        end
      end
    end
  end

  // Result side back-pressure, with one long hold to fill the engine up
  always @(negedge clk_i) begin
    logic calm;
    calm = quiet || (item_q.size() < CALM_TAIL);
    if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done     <= 1'b1;
      hold_left     <= LONG_HOLD - 1;
      m_axis_tready <= 1'b0;
    end else if (recv_gap != 0) begin
      recv_gap      <= recv_gap - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      recv_gap      <= $urandom_range(1, 14) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // --------------------------------------------------------------- monitor

  task automatic report_mismatch(string what, longint got, longint want);
    if (errors < MAX_PRINTS)
      $display("result %0d: %s got %0d, expected %0d", results_seen, what, got, want);
    errors++;
  endtask

  // Sample both handshakes at the rising edge; predict on input, check on output
  always @(posedge clk_i) begin
    req_t        req;
    fan_result_t got;
    fan_result_t want;
    logic        in_fire;
    logic        out_fire;
    in_fire  = rst_ni && s_axis_tvalid && s_axis_tready;
    out_fire = rst_ni && m_axis_tvalid && m_axis_tready;
    in_taken <= in_fire;
    if (in_fire) begin
      req.op  = s_axis_tuser;
      req.fan = s_axis_tdata[2:0];
      req.lvl = s_axis_tdata[10:3];
      req.rpm = s_axis_tdata[26:11];
      result_q.push_back(apply_fan_item(req));
    end
    if (out_fire) begin
      got.pwm   = m_axis_tdata[7:0];
      got.cmin  = m_axis_tdata[23:8];
      got.cmax  = m_axis_tdata[39:24];
      got.empty = m_axis_tdata[40];
      results_seen <= results_seen + 1;
      if (result_q.size() == 0) begin
        report_mismatch("result with nothing pending, pwm_out", got.pwm, 0);
      end else begin
        want = result_q.pop_front();
        if (got.pwm !== want.pwm) report_mismatch("pwm_out", got.pwm, want.pwm);
        if (got.cmin !== want.cmin) report_mismatch("curve_min", got.cmin, want.cmin);
        if (got.cmax !== want.cmax) report_mismatch("curve_max", got.cmax, want.cmax);
        if (got.empty !== want.empty)
          report_mismatch("curve_empty", got.empty, want.empty);
      end
    end
    // watchdog: too long with no handshake on either side
    if (in_fire || out_fire) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("fan_curve_table_engine: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ------------------------------------------------------------- sequence

  initial begin
    for (int f = 0; f < FANS; f++) begin
      for (int i = 0; i < LEVELS; i++) curve_shadow[f][i] = UNDEF_RPM;
      min_shadow[f] = '0;
      max_shadow[f] = '0;
    end
    fill_directed();
    fill_random();
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    // drain: every item taken, every result back
    while (item_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (result_q.size() != 0) @(posedge clk_i);
    // let any stray result show itself
    repeat (200) @(posedge clk_i);
    if (errors == 0 && result_q.size() == 0)
      $display("fan_curve_table_engine: match");
    else
      $display("fan_curve_table_engine: mismatch");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/fcte_pkg.sv
rtl/core/fcte_ram.sv
rtl/core/fcte_div.sv
rtl/core/fcte_seq.sv
rtl/core/fan_curve_table_engine.sv
tb/sv/tb_fan_curve_table_engine.sv
